FILE: sv/plac_pkg.sv
// Shared types, constants and control codes of the axis calibration block.
package plac_pkg;

  typedef logic signed [23:0] coord_t;
  typedef logic signed [31:0] value_t;
  typedef logic signed [19:0] frac_t;
  typedef logic [1:0]         status_t;
  typedef logic [2:0]         cfg_idx_t;

  // result status codes
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t REG_AXIS_DEFINED = 3'd0;
  localparam cfg_idx_t REG_AXIS_START_X = 3'd1;
  localparam cfg_idx_t REG_AXIS_START_Y = 3'd2;
  localparam cfg_idx_t REG_AXIS_END_X   = 3'd3;
  localparam cfg_idx_t REG_AXIS_END_Y   = 3'd4;
  localparam cfg_idx_t REG_RANGE_MIN    = 3'd5;
  localparam cfg_idx_t REG_RANGE_MAX    = 3'd6;

  localparam value_t RANGE_MAX_RESET = 32'sd65536;

  // fraction constants (Q3.16)
  localparam frac_t T_ZERO = 20'sd0;
  localparam frac_t T_ONE  = 20'sd65536;
  localparam frac_t T_HI   = 20'sd524287;
  localparam frac_t T_LO   = -20'sd524288;

  // divider geometry
  localparam int DIV_W     = 54;
  localparam int DIV_LOW_W = 32;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] PROJ_ITERS   = 6'd19;
  localparam logic [DIV_CNT_W-1:0] INTERP_ITERS = 6'd32;

  // datapath operation codes
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE  = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_DEN0  = 5'd2;
  localparam op_t OP_DEN1  = 5'd3;
  localparam op_t OP_CHK   = 5'd4;
  localparam op_t OP_NODE1 = 5'd5;
  localparam op_t OP_PX    = 5'd6;
  localparam op_t OP_PY    = 5'd7;
  localparam op_t OP_PDIV  = 5'd8;
  localparam op_t OP_PQ    = 5'd9;
  localparam op_t OP_PNODE = 5'd10;
  localparam op_t OP_FIN   = 5'd11;
  localparam op_t OP_M0    = 5'd12;
  localparam op_t OP_M1    = 5'd13;
  localparam op_t OP_IDIV  = 5'd14;
  localparam op_t OP_IRES  = 5'd15;
  localparam op_t OP_OUT   = 5'd16;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic sat;
    logic cnt_zero;
    logic last_point;
    logic div_busy;
    logic edge_hit;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/plac_if.sv
// Request, result and configuration channel interfaces.
interface plac_in_if;
  import plac_pkg::*;
  logic   valid;
  logic   ready;
  logic   func;
  coord_t point_x;
  coord_t point_y;
  value_t cal_value;
  frac_t  fraction;
  modport source (output valid, func, point_x, point_y, cal_value, fraction, input ready);
  modport sink (input valid, func, point_x, point_y, cal_value, fraction, output ready);
endinterface

interface plac_out_if;
  import plac_pkg::*;
  logic    valid;
  logic    ready;
  value_t  mapped_value;
  status_t status;
  modport source (output valid, mapped_value, status, input ready);
  modport sink (input valid, mapped_value, status, output ready);
endinterface

interface plac_cfg_if;
  import plac_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/piecewise_linear_axis_calibration.sv
// Top level of the piecewise-linear axis calibration block.
// A load request stores one calibration point in the table and returns status 0,
// or status 1 when the table is full and the point is dropped. A map request
// scans every stored point and ends early when the axis is undefined or of zero
// length, and skips the interpolation when the fraction lies at or outside the
// extreme nodes: each point costs two passes through the shared 25x25 multiplier
// and, unless its projection saturates, one run of the bit-serial divider, and the
// final interpolation one more divider run. One request is in work at a time; a
// finished result waits in the output register while the next request is taken.
module piecewise_linear_axis_calibration #(
  parameter int MAX_POINTS = 16
) (
  input logic        clk,
  input logic        rst,
  plac_in_if.sink    item,
  plac_out_if.source result,
  plac_cfg_if.sink   cfg
);
  import plac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  plac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  plac_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .point_x      (item.point_x),
    .point_y      (item.point_y),
    .cal_value    (item.cal_value),
    .fraction     (item.fraction),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .mapped_value (result.mapped_value),
    .status       (result.status)
  );

endmodule

FILE: sv/plac_div.sv
// Restoring divider, one quotient bit per cycle.
module plac_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [plac_pkg::DIV_W-1:0]     rem0,
  input  logic [plac_pkg::DIV_LOW_W-1:0] low0,
  input  logic [plac_pkg::DIV_W-1:0]     dvs,
  input  logic [plac_pkg::DIV_CNT_W-1:0] iters,
  output logic                           busy,
  output logic [plac_pkg::DIV_LOW_W-1:0] quo
);
  import plac_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_LOW_W-1:0] low;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     sh;

  assign sh   = {rem[DIV_W-2:0], low[DIV_LOW_W-1]};
  assign busy = (cnt != '0);

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // shift, compare and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem0;
      low   <= low0;
      dvs_r <= dvs;
      quo   <= '0;
    end else if (busy) begin
      low <= {low[DIV_LOW_W-2:0], 1'b0};
      if (sh >= dvs_r) begin
        rem <= sh - dvs_r;
        quo <= {quo[DIV_LOW_W-2:0], 1'b1};
      end else begin
        rem <= sh;
        quo <= {quo[DIV_LOW_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/plac_dp.sv
// Datapath: registers, point table, multiplier, divider, node tracking and output register.
module plac_dp #(
  parameter int MAX_POINTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  plac_pkg::cmd_t    cmd,
  output plac_pkg::sts_t    sts,
  input  plac_pkg::coord_t  point_x,
  input  plac_pkg::coord_t  point_y,
  input  plac_pkg::value_t  cal_value,
  input  plac_pkg::frac_t   fraction,
  input  logic              cfg_we,
  input  plac_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output plac_pkg::value_t  mapped_value,
  output plac_pkg::status_t status
);
  import plac_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // configuration registers
  logic   axis_defined;
  coord_t ax, ay, bx, by;
  value_t range_min, range_max;

  // captured request
  coord_t px_r, py_r;
  value_t cv_r;
  frac_t  f_r;

  // point table
  coord_t mem_x [MAX_POINTS];
  coord_t mem_y [MAX_POINTS];
  value_t mem_v [MAX_POINTS];
  coord_t rd_x, rd_y;
  value_t rd_v;
  logic [CW-1:0] point_count;
  logic [AW-1:0] idx;
  logic          full;

  // arithmetic
  logic signed [24:0] abx, aby, ma, mb;
  logic signed [49:0] prod;
  logic signed [54:0] acc, prod_ext;
  logic [49:0]        den_r;
  logic [DIV_W-1:0]   mag, den8;
  logic               acc_neg, neg_r;
  frac_t              t_cur;

  // node tracking
  logic   node_en, first;
  frac_t  nt;
  value_t nv;
  frac_t  min_t, max_t, lo_t, hi_t;
  value_t min_v, max_v, lo_v, hi_v;
  logic   lo_ok, hi_ok;

  // interpolation operands
  logic [19:0]        ia, dt_r;
  logic signed [20:0] d_ia, d_dt;
  logic signed [32:0] dv_r;
  frac_t              qf;
  logic [31:0]        qs;

  // divider
  logic                 div_start, div_busy;
  logic [DIV_W-1:0]     div_rem0, div_dvs;
  logic [DIV_LOW_W-1:0] div_low0, quo;
  logic [DIV_CNT_W-1:0] div_iters;

  // result and output register
  value_t  res_value;
  status_t res_status;

  assign abx  = 25'(bx) - 25'(ax);
  assign aby  = 25'(by) - 25'(ay);
  assign full = (point_count == CW'(MAX_POINTS));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_defined <= 1'b0;
      ax <= '0;
      ay <= '0;
      bx <= '0;
      by <= '0;
      range_min <= '0;
      range_max <= RANGE_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS_DEFINED: axis_defined <= cfg_data[0];
        REG_AXIS_START_X: ax <= cfg_data[23:0];
        REG_AXIS_START_Y: ay <= cfg_data[23:0];
        REG_AXIS_END_X:   bx <= cfg_data[23:0];
        REG_AXIS_END_Y:   by <= cfg_data[23:0];
        REG_RANGE_MIN:    range_min <= cfg_data;
        REG_RANGE_MAX:    range_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= point_x;
      py_r <= point_y;
      cv_r <= cal_value;
      f_r  <= fraction;
    end
  end

  // point table: write on a load that finds room, registered read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !full) begin
      mem_x[point_count[AW-1:0]] <= px_r;
      mem_y[point_count[AW-1:0]] <= py_r;
      mem_v[point_count[AW-1:0]] <= cv_r;
    end
    rd_x <= mem_x[idx];
    rd_y <= mem_y[idx];
    rd_v <= mem_v[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.op == OP_LOAD && !full) begin
      point_count <= point_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CHK) begin
      idx <= '0;
    end else if (cmd.op == OP_PNODE) begin
      idx <= idx + 1'b1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_DEN0: begin
        ma = abx;
        mb = abx;
      end
      OP_DEN1: begin
        ma = aby;
        mb = aby;
      end
      OP_PX: begin
        ma = 25'(rd_x) - 25'(ax);
        mb = abx;
      end
      OP_PY: begin
        ma = 25'(rd_y) - 25'(ay);
        mb = aby;
      end
      OP_M0: begin
        ma = $signed({5'b0, ia});
        mb = $signed({8'b0, dv_r[16:0]});
      end
      OP_M1: begin
        ma = $signed({5'b0, ia});
        mb = 25'($signed(dv_r[32:17]));
      end
      default: ;
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = 55'(prod);

  // accumulator
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_DEN0, OP_PX, OP_M0: acc <= prod_ext;
      OP_DEN1, OP_PY:        acc <= acc + prod_ext;
      OP_M1:                 acc <= acc + (prod_ext <<< 17);
      default: ;
    endcase
  end

  assign acc_neg = acc[54];
  assign mag     = acc_neg ? DIV_W'(-acc) : DIV_W'(acc);
  assign den8    = {1'b0, den_r, 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CHK) begin
      den_r <= acc[49:0];
    end
  end

  // divider set-up for projection and interpolation
  assign div_start = (cmd.op == OP_PDIV && !sts.sat) || (cmd.op == OP_IDIV);
  assign div_rem0  = (cmd.op == OP_IDIV) ? DIV_W'(mag[53:32]) : mag;
  assign div_low0  = (cmd.op == OP_IDIV) ? mag[31:0] : '0;
  assign div_dvs   = (cmd.op == OP_IDIV) ? DIV_W'(dt_r) : den8;
  assign div_iters = (cmd.op == OP_IDIV) ? INTERP_ITERS : PROJ_ITERS;

  plac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem0  (div_rem0),
    .low0  (div_low0),
    .dvs   (div_dvs),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (quo)
  );

  // projected position of the current point
  assign qf = frac_t'({1'b0, quo[18:0]});

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PDIV || cmd.op == OP_IDIV) begin
      neg_r <= acc_neg;
    end
    if (cmd.op == OP_PDIV) begin
      t_cur <= acc_neg ? T_LO : T_HI;
    end else if (cmd.op == OP_PQ) begin
      t_cur <= neg_r ? -qf : qf;
    end
  end

  // node feed
  always_comb begin
    node_en = 1'b0;
    first   = 1'b0;
    nt      = T_ZERO;
    nv      = range_min;
    unique case (cmd.op)
      OP_CHK: begin
        node_en = 1'b1;
        first   = 1'b1;
      end
      OP_NODE1: begin
        node_en = 1'b1;
        nt      = T_ONE;
        nv      = range_max;
      end
      OP_PNODE: begin
        node_en = 1'b1;
        nt      = t_cur;
        nv      = rd_v;
      end
      default: ;
    endcase
  end

  // extremes and fraction neighbours; min and hi keep the first tie, max and lo the last
  always_ff @(posedge clk) begin
    if (node_en) begin
      if (first || nt < min_t) begin
        min_t <= nt;
        min_v <= nv;
      end
      if (first || nt >= max_t) begin
        max_t <= nt;
        max_v <= nv;
      end
      if (nt < f_r) begin
        if (first || !lo_ok || nt >= lo_t) begin
          lo_t  <= nt;
          lo_v  <= nv;
          lo_ok <= 1'b1;
        end
      end else if (first) begin
        lo_ok <= 1'b0;
      end
      if (nt >= f_r) begin
        if (first || !hi_ok || nt < hi_t) begin
          hi_t  <= nt;
          hi_v  <= nv;
          hi_ok <= 1'b1;
        end
      end else if (first) begin
        hi_ok <= 1'b0;
      end
    end
  end

  // interpolation operands
  assign d_ia = 21'(f_r) - 21'(lo_t);
  assign d_dt = 21'(hi_t) - 21'(lo_t);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      ia   <= d_ia[19:0];
      dt_r <= d_dt[19:0];
      dv_r <= 33'(hi_v) - 33'(lo_v);
    end
  end

  assign qs = neg_r ? (~quo + 32'd1) : quo;

  // result register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        res_value  <= '0;
        res_status <= full ? ST_FULL : ST_OK;
      end
      OP_CHK: begin
        res_value  <= range_min;
        res_status <= ST_BAD;
      end
      OP_FIN: begin
        res_status <= ST_OK;
        res_value  <= (f_r <= min_t) ? min_v : max_v;
      end
      OP_IRES: begin
        res_value <= lo_v + $signed(qs);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      mapped_value <= res_value;
      status       <= res_status;
    end
  end

  // status to the controller
  assign sts.bad        = !axis_defined || (acc == '0);
  assign sts.sat        = (mag >= den8);
  assign sts.cnt_zero   = (point_count == '0);
  assign sts.last_point = ((CW'(idx) + CW'(1)) == point_count);
  assign sts.div_busy   = div_busy;
  assign sts.edge_hit   = (f_r <= min_t) || (f_r >= max_t);
  assign sts.out_free   = !out_valid || out_ready;

  // table never overfills, and a dropped point leaves the count alone
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CW'(MAX_POINTS)) else $error("point count beyond table size");
  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD && full) |=> $stable(point_count))
    else $error("dropped point changed the count");

endmodule

FILE: sv/plac_ctrl.sv
// Controller: sequences load and map requests over the datapath.
module plac_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_func,
  output logic           item_ready,
  input  plac_pkg::sts_t sts,
  output plac_pkg::cmd_t cmd
);
  import plac_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_DEN0  = 5'd2;
  localparam logic [4:0] S_DEN1  = 5'd3;
  localparam logic [4:0] S_CHK   = 5'd4;
  localparam logic [4:0] S_NODE1 = 5'd5;
  localparam logic [4:0] S_RD    = 5'd6;
  localparam logic [4:0] S_PX    = 5'd7;
  localparam logic [4:0] S_PY    = 5'd8;
  localparam logic [4:0] S_PDIV  = 5'd9;
  localparam logic [4:0] S_PWAIT = 5'd10;
  localparam logic [4:0] S_PQ    = 5'd11;
  localparam logic [4:0] S_PNODE = 5'd12;
  localparam logic [4:0] S_FIN   = 5'd13;
  localparam logic [4:0] S_M0    = 5'd14;
  localparam logic [4:0] S_M1    = 5'd15;
  localparam logic [4:0] S_IDIV  = 5'd16;
  localparam logic [4:0] S_IWAIT = 5'd17;
  localparam logic [4:0] S_IRES  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state, state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = item_func ? S_DEN0 : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_OUT;
      end
      S_DEN0: begin
        cmd.op     = OP_DEN0;
        state_next = S_DEN1;
      end
      S_DEN1: begin
        cmd.op     = OP_DEN1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.op     = OP_CHK;
        state_next = sts.bad ? S_OUT : S_NODE1;
      end
      S_NODE1: begin
        cmd.op     = OP_NODE1;
        state_next = sts.cnt_zero ? S_FIN : S_RD;
      end
      S_RD: state_next = S_PX;
      S_PX: begin
        cmd.op     = OP_PX;
        state_next = S_PY;
      end
      S_PY: begin
        cmd.op     = OP_PY;
        state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.op     = OP_PDIV;
        state_next = sts.sat ? S_PNODE : S_PWAIT;
      end
      S_PWAIT: begin
        if (!sts.div_busy) begin
          state_next = S_PQ;
        end
      end
      S_PQ: begin
        cmd.op     = OP_PQ;
        state_next = S_PNODE;
      end
      S_PNODE: begin
        cmd.op     = OP_PNODE;
        state_next = sts.last_point ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = sts.edge_hit ? S_OUT : S_M0;
      end
      S_M0: begin
        cmd.op     = OP_M0;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.op     = OP_M1;
        state_next = S_IDIV;
      end
      S_IDIV: begin
        cmd.op     = OP_IDIV;
        state_next = S_IWAIT;
      end
      S_IWAIT: begin
        if (!sts.div_busy) begin
          state_next = S_IRES;
        end
      end
      S_IRES: begin
        cmd.op     = OP_IRES;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.div_busy) else $error("divider busy while idle");
  a_pq_after_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_PQ) |-> ($past(state) == S_PWAIT)) else $error("quotient taken early");
  a_capture_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state != S_IDLE)) else $error("request taken but not started");

endmodule
